// ===== sv/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rainflow cycle counter package
// Shared constants, item types, stack request and result hand-off structs,
// and the range helper used by the sequencer.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0]        range_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              count_t;

    typedef enum logic [1:0] {
        KIND_FULL = 2'd0,
        KIND_HALF = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        sample_t sample;
        logic    last;
    } sample_item_t;

    typedef struct packed {
        kind_t   kind;
        range_t  cycle_range;
        sample_t start_value;
        sample_t end_value;
        logic    forced;
        logic    run_end;
    } result_item_t;

    typedef struct packed {
        logic    wr_en;
        idx_t    wr_idx;
        sample_t wr_data;
        idx_t    rd_idx_a;
        idx_t    rd_idx_b;
        logic    base_inc;
    } stack_req_t;

    typedef struct packed {
        logic         push;
        logic         close;
        result_item_t item;
    } emit_t;

    function automatic range_t span(input sample_t a, input sample_t b);
        logic [SAMPLE_BITS:0] diff;
        diff = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
        if (diff[SAMPLE_BITS])
        begin
            diff = -diff;
        end
        return diff[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== sv/rainflow_cycle_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Rainflow cycle counter
// Streaming three-point rainflow counter with a turning point stack memory.
// ----------------------------------------------------------------------------
// Usage: samples of a record enter on the sample channel one item at a time;
// last marks the final sample of the record. Counted ranges leave on the
// result channel as full or half cycles, and a record ends with an end marker
// that carries the largest counted range. run_end flags the last result
// caused by an input item; an item may cause no result at all.
// Sequence: each turning point is pushed onto the stack, then the three-point
// rule runs until it counts no more cycles; a full stack first drops its
// bottom point as a forced half cycle. On the last sample the residue is
// flushed as half cycles, one per stack pair with a nonzero range, before the
// end marker. The stack memory has registered read ports, which the sequencer
// reads two entries at a time. The sample channel stalls until the block is
// through with an item. The next item is taken while a result still waits on
// the output. A stalled result channel holds the block once its one held
// result and its output register are both full. Reset clears the stack count,
// sample history and largest range; stack contents need no clearing.
// ----------------------------------------------------------------------------
module rainflow_cycle_counter_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  rcc_pkg::sample_item_t sample_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rcc_pkg::result_item_t result_item
);
    import rcc_pkg::*;

    stack_req_t stack_req;
    sample_t    rd_data_a;
    sample_t    rd_data_b;
    emit_t      emit;
    logic       emit_ready;

    rcc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .emit_ready   (emit_ready),
        .stack_req    (stack_req),
        .emit         (emit)
    );

    rcc_stack u_stack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (stack_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rcc_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .ready        (emit_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== sv/rcc_stack.sv =====
// ----------------------------------------------------------------------------
// Rainflow turning point stack
// Ring-addressed stack memory with one write port and two registered read
// ports. Logical index zero is the stack bottom; the base pointer moves up
// when the bottom point is dropped.
// ----------------------------------------------------------------------------
module rcc_stack
(
    input  logic                clk,
    input  logic                rst_n,
    input  rcc_pkg::stack_req_t req,
    output rcc_pkg::sample_t    rd_data_a,
    output rcc_pkg::sample_t    rd_data_b
);
    import rcc_pkg::*;

    sample_t mem [STACK_DEPTH];
    idx_t    base_reg;
    idx_t    base_next;
    sample_t rd_a_reg;
    sample_t rd_b_reg;

    function automatic idx_t phys(input idx_t base, input idx_t i);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, i};
        if (sum >= (IDX_W + 1)'(STACK_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(STACK_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    always_comb
    begin
        base_next = base_reg;
        if (req.base_inc)
        begin
            if (base_reg == IDX_W'(STACK_DEPTH - 1))
            begin
                base_next = '0;
            end
            else
            begin
                base_next = base_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[phys(base_reg, req.wr_idx)] <= req.wr_data;
        end
        rd_a_reg <= mem[phys(base_reg, req.rd_idx_a)];
        rd_b_reg <= mem[phys(base_reg, req.rd_idx_b)];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== sv/rcc_out.sv =====
// ----------------------------------------------------------------------------
// Rainflow result stage
// Holds the newest result until it is known whether another one follows for
// the same item, then moves it to the output register with its end flag.
// ----------------------------------------------------------------------------
module rcc_out
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcc_pkg::emit_t        emit,
    output logic                  ready,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rcc_pkg::result_item_t result_item
);
    import rcc_pkg::*;

    logic         hold_valid_reg;
    logic         hold_valid_next;
    result_item_t hold_reg;
    result_item_t hold_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_item_t out_reg;
    result_item_t out_next;
    logic         load;

    assign ready = !hold_valid_reg || !out_valid_reg || !result_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        load            = 1'b0;
        if (emit.push && ready)
        begin
            if (hold_valid_reg)
            begin
                load             = 1'b1;
                out_next         = hold_reg;
                out_next.run_end = 1'b0;
            end
            hold_next       = emit.item;
            hold_valid_next = 1'b1;
        end
        else if (emit.close && ready && hold_valid_reg)
        begin
            load             = 1'b1;
            out_next         = hold_reg;
            out_next.run_end = 1'b1;
            hold_valid_next  = 1'b0;
        end
        out_valid_next = load || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

// ===== sv/rcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rainflow sequencer
// Detects turning points, pushes them onto the stack memory, runs the
// three-point rule by read-modify-write of the stack, handles overflow and
// flushes the residue at the end of a record.
// ----------------------------------------------------------------------------
module rcc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  rcc_pkg::sample_item_t sample_item,
    input  rcc_pkg::sample_t      rd_data_a,
    input  rcc_pkg::sample_t      rd_data_b,
    input  logic                  emit_ready,
    output rcc_pkg::stack_req_t   stack_req,
    output rcc_pkg::emit_t        emit
);
    import rcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_FORCE,
        S_RULE_RD,
        S_RULE_EX,
        S_NEXT,
        S_FLUSH_RD,
        S_FLUSH_EX,
        S_MARK,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    sample_t top_reg, top_next;
    sample_t prev_reg, prev_next;
    sample_t cand_reg, cand_next;
    logic [1:0] seen_reg, seen_next;
    range_t  max_reg, max_next;
    sample_t pv_reg, pv_next;
    logic    pb_valid_reg, pb_valid_next;
    sample_t pb_reg, pb_next;
    logic    fin_reg, fin_next;
    count_t  fidx_reg, fidx_next;

    logic [SAMPLE_BITS:0] d1;
    logic [SAMPLE_BITS:0] d2;
    logic    turning;
    range_t  y;
    range_t  x;
    sample_t s;

    assign s  = sample_item.sample;
    assign d1 = {cand_reg[SAMPLE_BITS-1], cand_reg} - {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign d2 = {s[SAMPLE_BITS-1], s} - {cand_reg[SAMPLE_BITS-1], cand_reg};
    assign turning = (!d1[SAMPLE_BITS] && (d1 != '0) && (d2[SAMPLE_BITS] || (d2 == '0)))
                  || (d1[SAMPLE_BITS] && !d2[SAMPLE_BITS]);
    assign y = span(rd_data_a, rd_data_b);
    assign x = span(rd_data_b, top_reg);

    assign sample_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        prev_next     = prev_reg;
        cand_next     = cand_reg;
        seen_next     = seen_reg;
        max_next      = max_reg;
        pv_next       = pv_reg;
        pb_valid_next = pb_valid_reg;
        pb_next       = pb_reg;
        fin_next      = fin_reg;
        fidx_next     = fidx_reg;
        stack_req     = '0;
        emit          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    fin_next      = sample_item.last;
                    pb_valid_next = 1'b0;
                    pb_next       = s;
                    if (seen_reg == 2'd0)
                    begin
                        pv_next    = s;
                        cand_next  = s;
                        seen_next  = 2'd1;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        prev_next = cand_reg;
                        cand_next = s;
                        seen_next = 2'd2;
                        if (seen_reg[1] && turning)
                        begin
                            pv_next       = cand_reg;
                            pb_valid_next = sample_item.last;
                            state_next    = S_PUSH;
                        end
                        else if (sample_item.last)
                        begin
                            pv_next    = s;
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_PUSH:
            begin
                if (count_reg == CNT_W'(STACK_DEPTH))
                begin
                    stack_req.rd_idx_a = '0;
                    stack_req.rd_idx_b = IDX_W'(1);
                    state_next         = S_FORCE;
                end
                else
                begin
                    stack_req.wr_en   = 1'b1;
                    stack_req.wr_idx  = IDX_W'(count_reg);
                    stack_req.wr_data = pv_reg;
                    top_next          = pv_reg;
                    count_next        = count_reg + CNT_W'(1);
                    state_next        = S_RULE_RD;
                end
            end

            S_FORCE:
            begin
                stack_req.rd_idx_a = '0;
                stack_req.rd_idx_b = IDX_W'(1);
                if (emit_ready)
                begin
                    emit.push             = 1'b1;
                    emit.item.kind        = KIND_HALF;
                    emit.item.cycle_range = y;
                    emit.item.start_value = rd_data_a;
                    emit.item.end_value   = rd_data_b;
                    emit.item.forced      = 1'b1;
                    if (y > max_reg)
                    begin
                        max_next = y;
                    end
                    stack_req.base_inc = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                    state_next         = S_PUSH;
                end
            end

            S_RULE_RD:
            begin
                if (count_reg >= CNT_W'(3))
                begin
                    stack_req.rd_idx_a = IDX_W'(count_reg - CNT_W'(3));
                    stack_req.rd_idx_b = IDX_W'(count_reg - CNT_W'(2));
                    state_next         = S_RULE_EX;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end

            S_RULE_EX:
            begin
                stack_req.rd_idx_a = IDX_W'(count_reg - CNT_W'(3));
                stack_req.rd_idx_b = IDX_W'(count_reg - CNT_W'(2));
                if ((x >= y) && (y != '0))
                begin
                    if (emit_ready)
                    begin
                        emit.push             = 1'b1;
                        emit.item.cycle_range = y;
                        emit.item.start_value = rd_data_a;
                        emit.item.end_value   = rd_data_b;
                        if (y > max_reg)
                        begin
                            max_next = y;
                        end
                        if (count_reg == CNT_W'(3))
                        begin
                            emit.item.kind     = KIND_HALF;
                            stack_req.base_inc = 1'b1;
                            count_next         = CNT_W'(2);
                        end
                        else
                        begin
                            emit.item.kind    = KIND_FULL;
                            stack_req.wr_en   = 1'b1;
                            stack_req.wr_idx  = IDX_W'(count_reg - CNT_W'(3));
                            stack_req.wr_data = top_reg;
                            count_next        = count_reg - CNT_W'(2);
                        end
                        state_next = S_RULE_RD;
                    end
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (pb_valid_reg)
                begin
                    pv_next       = pb_reg;
                    pb_valid_next = 1'b0;
                    state_next    = S_PUSH;
                end
                else if (fin_reg)
                begin
                    fidx_next  = '0;
                    state_next = S_FLUSH_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FLUSH_RD:
            begin
                if ((fidx_reg + CNT_W'(1)) < count_reg)
                begin
                    stack_req.rd_idx_a = IDX_W'(fidx_reg);
                    stack_req.rd_idx_b = IDX_W'(fidx_reg + CNT_W'(1));
                    state_next         = S_FLUSH_EX;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end

            S_FLUSH_EX:
            begin
                stack_req.rd_idx_a = IDX_W'(fidx_reg);
                stack_req.rd_idx_b = IDX_W'(fidx_reg + CNT_W'(1));
                if (y == '0)
                begin
                    fidx_next  = fidx_reg + CNT_W'(1);
                    state_next = S_FLUSH_RD;
                end
                else if (emit_ready)
                begin
                    emit.push             = 1'b1;
                    emit.item.kind        = KIND_HALF;
                    emit.item.cycle_range = y;
                    emit.item.start_value = rd_data_a;
                    emit.item.end_value   = rd_data_b;
                    if (y > max_reg)
                    begin
                        max_next = y;
                    end
                    fidx_next  = fidx_reg + CNT_W'(1);
                    state_next = S_FLUSH_RD;
                end
            end

            S_MARK:
            begin
                if (emit_ready)
                begin
                    emit.push             = 1'b1;
                    emit.item.kind        = KIND_END;
                    emit.item.cycle_range = max_reg;
                    count_next            = '0;
                    prev_next             = '0;
                    cand_next             = '0;
                    seen_next             = 2'd0;
                    max_next              = '0;
                    fin_next              = 1'b0;
                    state_next            = S_DONE;
                end
            end

            S_DONE:
            begin
                emit.close = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            top_reg      <= '0;
            prev_reg     <= '0;
            cand_reg     <= '0;
            seen_reg     <= 2'd0;
            max_reg      <= '0;
            pv_reg       <= '0;
            pb_valid_reg <= 1'b0;
            pb_reg       <= '0;
            fin_reg      <= 1'b0;
            fidx_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            prev_reg     <= prev_next;
            cand_reg     <= cand_next;
            seen_reg     <= seen_next;
            max_reg      <= max_next;
            pv_reg       <= pv_next;
            pb_valid_reg <= pb_valid_next;
            pb_reg       <= pb_next;
            fin_reg      <= fin_next;
            fidx_reg     <= fidx_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    a_rule_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RULE_EX |-> count_reg >= CNT_W'(3))
        else $error("Three-point rule evaluated on fewer than three points.");

    a_force_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FORCE |-> count_reg == CNT_W'(STACK_DEPTH))
        else $error("Overflow drop taken on a stack that is not full.");

    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        emit.push |-> emit_ready)
        else $error("Result produced while the result stage could not take it.");

    a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK && emit_ready
        |=> count_reg == '0 && seen_reg == 2'd0 && max_reg == '0)
        else $error("Record state not cleared after the end marker.");

endmodule
